/* rtl/lae_pkg.sv */
// Shared types and constants for the life automaton engine.
package lae_pkg;

  // Field widths of the request and result
  localparam int unsigned OpW  = 2;
  localparam int unsigned RowW = 6;
  localparam int unsigned ColW = 6;

  // Default grid size
  localparam int unsigned GridRowsDef = 64;
  localparam int unsigned GridColsDef = 64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  // Request operation codes
  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // One column's view of the three rows around the row being updated
  typedef struct packed {
    logic above;
    logic cur;
    logic below;
  } col_t;

  // Control from the sequencer to every column cell
  typedef struct packed {
    logic load;   // start of pass: cur takes the first row, above is cleared
    logic shift;  // above takes cur, cur takes below
  } cell_ctrl_t;

endpackage

/* rtl/lae_cell.sv */
// One column cell: holds the old above/current bits and computes the new bit.
module lae_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lae_pkg::cell_ctrl_t ctrl_i,
  input  logic                below_i,
  input  lae_pkg::col_t       west_i,
  input  lae_pkg::col_t       east_i,
  output lae_pkg::col_t       col_o,
  output logic                next_o
);

  logic       above_q, above_d;
  logic       cur_q, cur_d;
  logic [3:0] count;

  // Old-generation bits of this column
  always_comb begin
    above_d = above_q;
    cur_d   = cur_q;
    if (ctrl_i.load) begin
      above_d = 1'b0;
      cur_d   = below_i;
    end else if (ctrl_i.shift) begin
      above_d = cur_q;
      cur_d   = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      cur_q   <= 1'b0;
    end else begin
      above_q <= above_d;
      cur_q   <= cur_d;
    end
  end

  // Bits handed to both neighbors
  assign col_o = '{above: above_q, cur: cur_q, below: below_i};

  // Neighbor count and B3/S23 rule
  assign count = 4'(west_i.above) + 4'(west_i.cur) + 4'(west_i.below)
               + 4'(above_q) + 4'(below_i)
               + 4'(east_i.above) + 4'(east_i.cur) + 4'(east_i.below);

  assign next_o = (count == lae_pkg::BirthCount) ||
                  (cur_q && (count == lae_pkg::SurviveCount));

endmodule

/* rtl/life_automaton_engine.sv */
// Top level: grid memory, request sequencer and the chain of column cells.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with op_i, row_i, col_i and
//   alive_i; a request is taken at a clock edge with in_valid_i high and
//   in_stall_o low. Every request returns exactly one result on
//   out_valid_o / out_stall_i: cell_alive_o is the read cell for a read and
//   zero for write, clear and step. Cells outside the grid read as dead and
//   ignore writes.
//   Requests are taken one at a time: in_stall_o is high until the sequencer
//   is idle again. A generation step streams one grid row per cycle through
//   the single read port of the grid memory into a row of GRID_COLS column
//   cells, and writes each new row back two rows behind the row being read.
//   Reset: the grid memory is cleared one row per cycle, and in_stall_o stays
//   high until every row has been cleared.
//   A stalled result is held in the output register; the next request is
//   still taken, and its result waits until the held one is taken.
module life_automaton_engine #(
  parameter int unsigned GRID_ROWS = lae_pkg::GridRowsDef,
  parameter int unsigned GRID_COLS = lae_pkg::GridColsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [lae_pkg::OpW-1:0]  op_i,
  input  logic [lae_pkg::RowW-1:0] row_i,
  input  logic [lae_pkg::ColW-1:0] col_i,
  input  logic                     alive_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     cell_alive_o
);

  localparam int unsigned RowAw = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned ColAw = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned StepW = $clog2(GRID_ROWS + 2);

  localparam logic [StepW-1:0] LastRow  = StepW'(GRID_ROWS - 1);
  localparam logic [StepW-1:0] RowsStep = StepW'(GRID_ROWS);
  localparam logic [StepW-1:0] LastStep = StepW'(GRID_ROWS + 1);
  localparam logic [StepW-1:0] StepOne  = StepW'(1);
  localparam logic [StepW-1:0] StepTwo  = StepW'(2);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ACCESS = 5'b00100,
    ST_GEN    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [StepW-1:0]         step_q, step_d;
  logic                     from_op_q, from_op_d;
  lae_pkg::op_e             op_q, op_d;
  logic [RowAw-1:0]         row_q, row_d;
  logic [ColAw-1:0]         col_q, col_d;
  logic                     alive_q, alive_d;
  logic                     inside_q, inside_d;
  logic                     res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  logic                     cell_alive_q, cell_alive_d;

  logic [GRID_COLS-1:0]     mem_q [GRID_ROWS];
  logic [GRID_COLS-1:0]     rdata_q;
  logic [RowAw-1:0]         rd_addr;
  logic                     mem_we;
  logic [RowAw-1:0]         mem_waddr;
  logic [GRID_COLS-1:0]     mem_wdata;
  logic [GRID_COLS-1:0]     cell_word;

  logic                     accept;
  logic                     out_free;
  logic                     in_inside;
  lae_pkg::cell_ctrl_t      ctrl;
  logic [GRID_COLS-1:0]     below_v;
  logic [GRID_COLS-1:0]     next_v;
  lae_pkg::col_t            col_v [GRID_COLS];

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_inside = (32'(row_i) < GRID_ROWS) && (32'(col_i) < GRID_COLS);

  // Read address: the request's row when idle, the streamed row in a pass
  always_comb begin
    rd_addr = RowAw'(row_i);
    if (state_q == ST_GEN) begin
      rd_addr = step_q[RowAw-1:0];
    end
  end

  // Write of one cell into the row word read for it
  always_comb begin
    cell_word         = rdata_q;
    cell_word[col_q]  = alive_q;
  end

  // Column cell control and the row coming in below
  assign ctrl.load  = (state_q == ST_GEN) && (step_q == StepOne);
  assign ctrl.shift = (state_q == ST_GEN) && (step_q >= StepTwo) && (step_q <= RowsStep);
  assign below_v    = (step_q == LastStep) ? '0 : rdata_q;

  // Chain of column cells; columns past the edges count as dead
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    lae_pkg::col_t west, east;
    if (c == 0) begin : g_west_edge
      assign west = '0;
    end else begin : g_west
      assign west = col_v[c-1];
    end
    if (c == GRID_COLS - 1) begin : g_east_edge
      assign east = '0;
    end else begin : g_east
      assign east = col_v[c+1];
    end
    lae_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .below_i (below_v[c]),
      .west_i  (west),
      .east_i  (east),
      .col_o   (col_v[c]),
      .next_o  (next_v[c])
    );
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    from_op_d    = from_op_q;
    op_d         = op_q;
    row_d        = row_q;
    col_d        = col_q;
    alive_d      = alive_q;
    inside_d     = inside_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = step_q[RowAw-1:0];
    mem_wdata    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = step_q[RowAw-1:0];
        mem_wdata = '0;
        step_d    = step_q + StepOne;
        if (step_q == LastRow) begin
          step_d  = '0;
          state_d = from_op_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          from_op_d = 1'b1;
          op_d      = lae_pkg::op_e'(op_i);
          row_d     = RowAw'(row_i);
          col_d     = ColAw'(col_i);
          alive_d   = alive_i;
          inside_d  = in_inside;
          res_d     = 1'b0;
          step_d    = '0;
          unique case (lae_pkg::op_e'(op_i))
            lae_pkg::OP_WRITE: state_d = ST_ACCESS;
            lae_pkg::OP_READ:  state_d = ST_ACCESS;
            lae_pkg::OP_STEP:  state_d = ST_GEN;
            lae_pkg::OP_CLEAR: state_d = ST_CLEAR;
            default:           state_d = ST_ACCESS;
          endcase
        end
      end
      ST_ACCESS: begin
        if (inside_q) begin
          if (op_q == lae_pkg::OP_READ) begin
            res_d = rdata_q[col_q];
          end else begin
            mem_we    = 1'b1;
            mem_waddr = row_q;
            mem_wdata = cell_word;
          end
        end
        state_d = ST_DONE;
      end
      ST_GEN: begin
        // step s reads row s and writes new row s-2
        if (step_q >= StepTwo) begin
          mem_we    = 1'b1;
          mem_waddr = RowAw'(step_q - StepTwo);
          mem_wdata = next_v;
        end
        step_d = step_q + StepOne;
        if (step_q == LastStep) begin
          step_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    cell_alive_d = cell_alive_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d  = 1'b1;
      cell_alive_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      from_op_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      from_op_q   <= from_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    row_q        <= row_d;
    col_q        <= col_d;
    alive_q      <= alive_d;
    inside_q     <= inside_d;
    res_q        <= res_d;
    cell_alive_q <= cell_alive_d;
  end

  // Grid memory: one row word per entry, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign cell_alive_o = cell_alive_q;

  // A new row is never written over a row still to be read in a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && step_q >= StepTwo && step_q < RowsStep) |->
      (mem_waddr != rd_addr))
    else $error("generation pass writes the row being read");

  // The pass counter never runs past the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (step_q <= LastStep))
    else $error("generation step counter out of range");

  // A taken request always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("request taken but sequencer stayed idle");

endmodule
